// ----- sv/rbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the 2D ray versus box slab intersection block.
package rbs_pkg;

    localparam int COORD_W = 32;
    localparam int DIR_W   = 16;
    localparam int FRAC_W  = 14;
    localparam int MAG_W   = 34;
    localparam int DVD_W   = MAG_W + FRAC_W;
    localparam int T_W     = DVD_W + 2;
    localparam int IN_W    = 6 * COORD_W + 2 * DIR_W;
    localparam int OUT_W   = 40;

    typedef logic signed [T_W-1:0] t_dist;

    localparam t_dist T_POS_INF = {2'b01, {DVD_W{1'b0}}};
    localparam t_dist T_NEG_INF = {2'b11, {DVD_W{1'b0}}};
    localparam logic [COORD_W-1:0] MISS_DIST = 32'hFFFF_0000;
    localparam logic [COORD_W-1:0] DIST_MAX  = 32'h7FFF_FFFF;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic zero;
        logic ok;
    } t_flags;

    typedef struct packed {
        t_flags x;
        t_flags y;
    } t_side;

    typedef struct packed {
        logic [DIR_W-1:0] dsr;
        logic [DVD_W-1:0] dvd_a;
        logic [DVD_W-1:0] dvd_b;
        t_flags           flg;
    } t_axis;

    typedef struct packed {
        t_axis x;
        t_axis y;
    } t_query;

endpackage

// ----- sv/rbs_front.sv -----
`timescale 1ns / 1ps
// Front end: box corners, plane offsets and divide operands for both axes.
module rbs_front (
    input  logic [rbs_pkg::IN_W-1:0] i_data,
    output rbs_pkg::t_query          o_query
);
    import rbs_pkg::*;

    function automatic t_axis classify(
        input logic signed [COORD_W-1:0] c,
        input logic signed [COORD_W-1:0] h,
        input logic signed [COORD_W-1:0] o,
        input logic signed [DIR_W-1:0]   d
    );
        logic signed [MAG_W-1:0] p1;
        logic signed [MAG_W-1:0] p2;
        logic signed [MAG_W-1:0] bmin;
        logic signed [MAG_W-1:0] bmax;
        logic signed [MAG_W:0]   na;
        logic signed [MAG_W:0]   nb;
        logic        [MAG_W:0]   ma;
        logic        [MAG_W:0]   mb;
        logic signed [DIR_W:0]   de;
        t_axis                   r;
        p1   = MAG_W'(c) + MAG_W'(h);
        p2   = MAG_W'(c) - MAG_W'(h);
        bmin = (p1 < p2) ? p1 : p2;
        bmax = (p1 < p2) ? p2 : p1;
        na   = (MAG_W+1)'(bmin) - (MAG_W+1)'(o);
        nb   = (MAG_W+1)'(bmax) - (MAG_W+1)'(o);
        ma   = na[MAG_W] ? -na : na;
        mb   = nb[MAG_W] ? -nb : nb;
        de   = (DIR_W+1)'(d);
        r.dsr       = de[DIR_W] ? DIR_W'(-de) : DIR_W'(de);
        r.dvd_a     = {ma[MAG_W-1:0], {FRAC_W{1'b0}}};
        r.dvd_b     = {mb[MAG_W-1:0], {FRAC_W{1'b0}}};
        r.flg.neg_a = na[MAG_W] ^ d[DIR_W-1];
        r.flg.neg_b = nb[MAG_W] ^ d[DIR_W-1];
        r.flg.zero  = (d == '0);
        r.flg.ok    = (d != '0) || (na <= 0 && nb >= 0);
        return r;
    endfunction

    always_comb begin
        o_query.x = classify(i_data[0*COORD_W +: COORD_W], i_data[2*COORD_W +: COORD_W],
                             i_data[4*COORD_W +: COORD_W], i_data[6*COORD_W +: DIR_W]);
        o_query.y = classify(i_data[1*COORD_W +: COORD_W], i_data[3*COORD_W +: COORD_W],
                             i_data[5*COORD_W +: COORD_W],
                             i_data[6*COORD_W+DIR_W +: DIR_W]);
    end

endmodule

// ----- sv/rbs_fifo.sv -----
`timescale 1ns / 1ps
// Short queue of classified queries between front end and back end.
module rbs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rbs_pkg::t_query i_data,
    output logic            o_full,
    input  logic            i_pop,
    output rbs_pkg::t_query o_data,
    output logic            o_empty
);
    import rbs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_query          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_cnt;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= inc(r_wr);
            if (i_pop)  r_rd <= inc(r_rd);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

endmodule

// ----- sv/rbs_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
module rbs_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [rbs_pkg::DVD_W-1:0] i_dvd,
    input  logic [rbs_pkg::DIR_W-1:0] i_dsr,
    output logic [rbs_pkg::DVD_W-1:0] o_quo
);
    import rbs_pkg::*;

    logic [DVD_W-1:0] r_x   [DVD_W];
    logic [DIR_W-1:0] r_rem [DVD_W];
    logic [DIR_W-1:0] r_dsr [DVD_W];

    for (genvar k = 0; k < DVD_W; k++) begin : g_stg
        logic [DVD_W-1:0] x_in;
        logic [DIR_W-1:0] rem_in;
        logic [DIR_W-1:0] dsr_in;
        logic [DIR_W:0]   t;
        logic             q;

        if (k == 0) begin : g_first
            assign x_in   = i_dvd;
            assign rem_in = '0;
            assign dsr_in = i_dsr;
        end else begin : g_next
            assign x_in   = r_x[k-1];
            assign rem_in = r_rem[k-1];
            assign dsr_in = r_dsr[k-1];
        end

        assign t = {rem_in, x_in[DVD_W-1]};
        assign q = (t >= {1'b0, dsr_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= {x_in[DVD_W-2:0], q};
                r_rem[k] <= q ? DIR_W'(t - {1'b0, dsr_in}) : t[DIR_W-1:0];
                r_dsr[k] <= dsr_in;
            end
        end
    end

    assign o_quo = r_x[DVD_W-1];

endmodule

// ----- sv/rbs_back.sv -----
`timescale 1ns / 1ps
// Back end: four plane divisions, slab intersection, hit decision and output register.
module rbs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rbs_pkg::t_query             i_query,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_hit,
    output logic [rbs_pkg::COORD_W-1:0] o_dist
);
    import rbs_pkg::*;

    logic             en;
    logic [DVD_W-1:0] q_ax, q_bx, q_ay, q_by;
    logic             r_vld  [DVD_W];
    t_side            r_side [DVD_W];

    logic  r_a_vld;
    logic  r_a_ok;
    t_dist r_lox, r_hix, r_loy, r_hiy;
    logic  r_b_vld;
    logic  r_b_ok;
    t_dist r_tmin, r_tmax;
    logic  r_out_vld;
    logic  r_hit;
    logic [COORD_W-1:0] r_dist;

    t_dist ta_x, tb_x, ta_y, tb_y;
    t_dist tmin, tmax, tsel;
    t_side s_end;

    assign en    = !r_out_vld || i_ready;
    assign o_pop = en && !i_empty;

    rbs_div u_div_ax (.i_clk, .i_en(en), .i_dvd(i_query.x.dvd_a), .i_dsr(i_query.x.dsr),
                      .o_quo(q_ax));
    rbs_div u_div_bx (.i_clk, .i_en(en), .i_dvd(i_query.x.dvd_b), .i_dsr(i_query.x.dsr),
                      .o_quo(q_bx));
    rbs_div u_div_ay (.i_clk, .i_en(en), .i_dvd(i_query.y.dvd_a), .i_dsr(i_query.y.dsr),
                      .o_quo(q_ay));
    rbs_div u_div_by (.i_clk, .i_en(en), .i_dvd(i_query.y.dvd_b), .i_dsr(i_query.y.dsr),
                      .o_quo(q_by));

    for (genvar k = 0; k < DVD_W; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= (k == 0) ? !i_empty : r_vld[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[k] <= (k == 0) ? t_side'{x: i_query.x.flg, y: i_query.y.flg}
                                      : r_side[(k == 0) ? 0 : k-1];
            end
        end
    end

    function automatic t_dist signed_q(input logic [DVD_W-1:0] q, input logic neg);
        t_dist e;
        e = t_dist'({2'b00, q});
        return neg ? -e : e;
    endfunction

    always_comb begin
        s_end = r_side[DVD_W-1];
        ta_x  = signed_q(q_ax, s_end.x.neg_a);
        tb_x  = signed_q(q_bx, s_end.x.neg_b);
        ta_y  = signed_q(q_ay, s_end.y.neg_a);
        tb_y  = signed_q(q_by, s_end.y.neg_b);
        tmin  = (r_lox > r_loy) ? r_lox : r_loy;
        tmax  = (r_hix < r_hiy) ? r_hix : r_hiy;
        tsel  = (r_tmin < 0) ? r_tmax : r_tmin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_a_vld   <= r_vld[DVD_W-1];
            r_b_vld   <= r_a_vld;
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ok <= s_end.x.ok && s_end.y.ok;
            r_lox  <= s_end.x.zero ? T_NEG_INF : ((ta_x < tb_x) ? ta_x : tb_x);
            r_hix  <= s_end.x.zero ? T_POS_INF : ((ta_x < tb_x) ? tb_x : ta_x);
            r_loy  <= s_end.y.zero ? T_NEG_INF : ((ta_y < tb_y) ? ta_y : tb_y);
            r_hiy  <= s_end.y.zero ? T_POS_INF : ((ta_y < tb_y) ? tb_y : ta_y);
            r_b_ok <= r_a_ok;
            r_tmin <= tmin;
            r_tmax <= tmax;
            if (!r_b_ok || r_tmax < 0 || r_tmin > r_tmax) begin
                r_hit  <= 1'b0;
                r_dist <= MISS_DIST;
            end else begin
                r_hit  <= 1'b1;
                r_dist <= (tsel > t_dist'({1'b0, DIST_MAX})) ? DIST_MAX : tsel[COORD_W-1:0];
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_hit   = r_hit;
    assign o_dist  = r_dist;

endmodule

// ----- sv/ray_box_slab_intersect_2d.sv -----
`timescale 1ns / 1ps
// Top level of the 2D ray versus axis-aligned box slab intersection block.
// One query is taken per cycle while the input queue is not full, and one result
// leaves per query, in order. An accepted query passes through the input queue,
// the bit-per-stage dividers that give the four plane distances, and registers for
// the per-axis slab bounds, the slab intersection and the hit decision held in the
// output register. The back end stalls as a whole while a result waits; the input
// queue keeps taking queries until it holds FIFO_DEPTH of them.
module ray_box_slab_intersect_2d #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // box_center_x, box_center_y, box_half_x, box_half_y,
    // ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y
    input  logic [rbs_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // hit, distance, zero fill
    output logic [rbs_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import rbs_pkg::*;

    t_query             query_in;
    t_query             query_out;
    logic               full;
    logic               empty;
    logic               pop;
    logic               hit;
    logic [COORD_W-1:0] hit_dist;

    rbs_front u_front (
        .i_data  (i_s_axis_tdata),
        .o_query (query_in)
    );

    rbs_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk,
        .i_rst_n,
        .i_push  (i_s_axis_tvalid && !full),
        .i_data  (query_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (query_out),
        .o_empty (empty)
    );

    rbs_back u_back (
        .i_clk,
        .i_rst_n,
        .i_query (query_out),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_hit   (hit),
        .o_dist  (hit_dist)
    );

    assign o_s_axis_tready = !full;
    assign o_m_axis_tdata  = {(OUT_W-COORD_W-1)'(0), hit_dist, hit};

endmodule
